@@ src/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and fixed widths for the 4x4 matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

  // Fixed field widths
  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mm4_state_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic left_we;
    logic right_we;
    logic adv;
  } lane_ctl_t;

endpackage

@@ src/mm4_lane.sv @@
// ----------------------------------------------------------------------------
// mm4_lane
// One multiply lane: holds column k of the left matrix and row k of the
// right matrix, reads one element of each and forms their full product.
// ----------------------------------------------------------------------------
module mm4_lane #(
  parameter int DIM = 4,
  parameter int IW  = 2
) (
  input  logic                                 clk,
  input  mm4_pkg::lane_ctl_t                   ctl,
  input  logic [IW-1:0]                        wr_row,
  input  logic [IW-1:0]                        wr_col,
  input  logic signed [mm4_pkg::DATA_W-1:0]    wr_left,
  input  logic signed [mm4_pkg::DATA_W-1:0]    wr_right,
  input  logic [IW-1:0]                        rd_row,
  input  logic [IW-1:0]                        rd_col,
  output logic signed [mm4_pkg::PROD_W-1:0]    prod
);
  import mm4_pkg::*;

  logic signed [DATA_W-1:0] left_mem  [DIM];
  logic signed [DATA_W-1:0] right_mem [DIM];
  logic signed [DATA_W-1:0] left_q_r;
  logic signed [DATA_W-1:0] right_q_r;
  logic signed [PROD_W-1:0] prod_r;

  // Store left[row][k] by row, right[k][col] by column
  always_ff @(posedge clk) begin
    if (ctl.left_we) begin
      left_mem[wr_row] <= wr_left;
    end
    if (ctl.right_we) begin
      right_mem[wr_col] <= wr_right;
    end
  end

  // Registered read, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      left_q_r  <= left_mem[rd_row];
      right_q_r <= right_mem[rd_col];
    end
  end

  // Full-precision product
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r <= PROD_W'(left_q_r) * PROD_W'(right_q_r);
    end
  end

  assign prod = prod_r;

endmodule

@@ src/mm4_merge.sv @@
// ----------------------------------------------------------------------------
// mm4_merge
// Combines the lane products: pairwise add, final add, then arithmetic
// shift by the fraction width and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm4_merge #(
  parameter int DIM = 4
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [mm4_pkg::PROD_W-1:0]    prod [DIM],
  output logic signed [mm4_pkg::DATA_W-1:0]    result
);
  import mm4_pkg::*;

  localparam int NP = (DIM + 1) / 2;
  localparam int SW = PROD_W + $clog2(DIM) + 1;

  logic signed [SW-1:0]     pair_nxt [NP];
  logic signed [SW-1:0]     pair_r   [NP];
  logic signed [SW-1:0]     sum_nxt;
  logic signed [SW-1:0]     sum_r;
  logic signed [SW-1:0]     shifted;
  logic                     fits;
  logic signed [DATA_W-1:0] result_nxt;
  logic signed [DATA_W-1:0] result_r;

  // Add lane products in pairs
  for (genvar p = 0; p < NP; p++) begin : g_pair
    if (2 * p + 1 < DIM) begin : g_two
      assign pair_nxt[p] = SW'(prod[2*p]) + SW'(prod[2*p+1]);
    end else begin : g_one
      assign pair_nxt[p] = SW'(prod[2*p]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_r <= pair_nxt;
    end
  end

  // Sum the pair results
  always_comb begin
    sum_nxt = '0;
    for (int p = 0; p < NP; p++) begin
      sum_nxt = sum_nxt + pair_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  // Floor shift and clamp to the signed 32-bit range
  always_comb begin
    shifted = sum_r >>> FRAC_W;
    fits    = (shifted[SW-1:DATA_W-1] == '0) || (shifted[SW-1:DATA_W-1] == '1);
    if (fits) begin
      result_nxt = shifted[DATA_W-1:0];
    end else if (shifted[SW-1]) begin
      result_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

@@ src/matrix_multiply_4x4_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit
// Streaming DIM x DIM signed Q16.16 matrix product with one lane per term.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel loads one element of the left and of the right matrix
//   per transaction at row-major position in_elem_index. Indexes at or above
//   DIM*DIM are dropped. Loads may come back to back while no run is active.
//   The transaction for the last position starts a run: the block raises
//   in_stall while a sequencer steps through the product positions, and emits
//   DIM*DIM results on the out_ channel in row-major order, out_last_elem
//   high on the final one. Each result is formed by DIM multiply lanes
//   (one per term) and a merge stage; once out_valid rises, results follow
//   one per cycle while out_ is not stalled.
//   A stall on out_ freezes the whole result pipeline and the sequencer;
//   nothing is lost. Reset clears the sequencer and all valid flags; the
//   matrix stores are not cleared and must be loaded before a run.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit #(
  parameter int DIM = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mm4_pkg::IDX_W-1:0]          in_elem_index,
  input  logic signed [mm4_pkg::DATA_W-1:0]  in_left_value,
  input  logic signed [mm4_pkg::DATA_W-1:0]  in_right_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mm4_pkg::IDX_W-1:0]          out_index,
  output logic signed [mm4_pkg::DATA_W-1:0]  out_product_value,
  output logic                               out_last_elem
);
  import mm4_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int IW    = $clog2(DIM);
  localparam int PW    = $clog2(CELLS);
  localparam int NIDX  = 2 ** IDX_W;
  localparam int DEPTH = 5;

  // Index decode tables
  logic [IDX_W-1:0] row_tab [NIDX];
  logic [IDX_W-1:0] col_tab [NIDX];

  for (genvar i = 0; i < NIDX; i++) begin : g_tab
    assign row_tab[i] = IDX_W'(i / DIM);
    assign col_tab[i] = IDX_W'(i % DIM);
  end

  mm4_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_row_r, cnt_row_nxt;
  logic [IW-1:0] cnt_col_r, cnt_col_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          vld_r [DEPTH];
  logic [PW-1:0] spos_r [DEPTH];

  logic          in_acc;
  logic          idx_ok;
  logic          idx_last;
  logic [IW-1:0] in_row;
  logic [IW-1:0] in_col;
  logic          adv;
  logic          issue;
  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [DATA_W-1:0] merged;

  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = 32'(in_elem_index) < CELLS;
  assign idx_last = 32'(in_elem_index) == CELLS - 1;
  assign in_row   = row_tab[in_elem_index][IW-1:0];
  assign in_col   = col_tab[in_elem_index][IW-1:0];
  assign adv      = !vld_r[DEPTH-1] || !out_stall;
  assign issue    = (state_r == ST_RUN) && adv;
  assign in_stall = (state_r == ST_RUN);

  // Sequencer: next state and position counters
  always_comb begin
    state_nxt   = state_r;
    cnt_row_nxt = cnt_row_r;
    cnt_col_nxt = cnt_col_r;
    pos_nxt     = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && idx_ok && idx_last) begin
          state_nxt   = ST_RUN;
          cnt_row_nxt = '0;
          cnt_col_nxt = '0;
          pos_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          pos_nxt = pos_r + PW'(1);
          if (cnt_col_r == IW'(DIM - 1)) begin
            cnt_col_nxt = '0;
            cnt_row_nxt = cnt_row_r + IW'(1);
          end else begin
            cnt_col_nxt = cnt_col_r + IW'(1);
          end
          if (pos_r == PW'(CELLS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_row_r <= '0;
      cnt_col_r <= '0;
      pos_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_row_r <= cnt_row_nxt;
      cnt_col_r <= cnt_col_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // Track valid and position alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEPTH; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= issue;
      for (int s = 1; s < DEPTH; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spos_r[0] <= pos_r;
      for (int s = 1; s < DEPTH; s++) begin
        spos_r[s] <= spos_r[s-1];
      end
    end
  end

  // Multiply lanes, one per term of the dot product
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    lane_ctl_t ctl;

    assign ctl.left_we  = in_acc && idx_ok && (in_col == IW'(k));
    assign ctl.right_we = in_acc && idx_ok && (in_row == IW'(k));
    assign ctl.adv      = adv;

    mm4_lane #(
      .DIM (DIM),
      .IW  (IW)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .wr_row   (in_row),
      .wr_col   (in_col),
      .wr_left  (in_left_value),
      .wr_right (in_right_value),
      .rd_row   (cnt_row_r),
      .rd_col   (cnt_col_r),
      .prod     (prod[k])
    );
  end

  mm4_merge #(
    .DIM (DIM)
  ) u_merge (
    .clk    (clk),
    .adv    (adv),
    .prod   (prod),
    .result (merged)
  );

  assign out_valid         = vld_r[DEPTH-1];
  assign out_index         = IDX_W'(spos_r[DEPTH-1]);
  assign out_product_value = merged;
  assign out_last_elem     = (spos_r[DEPTH-1] == PW'(CELLS - 1));

  // Checks
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_elem |-> out_index == IDX_W'(CELLS - 1))
    else $error("last flag on wrong position");

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && idx_ok && idx_last |=> state_r == ST_RUN)
    else $error("run not started after last load");

  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    issue && pos_r == PW'(CELLS - 1) |=> state_r == ST_IDLE)
    else $error("run did not end after final position");

endmodule

@@ tb/tb_matrix_multiply_4x4_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_4x4_unit
// Self-checking bench for the streaming 4x4 signed Q16.16 matrix product.
// Loads are predicted into a local copy of both matrices. Each load of the
// last position queues the sixteen product elements, which are compared in
// order against the out_ channel. Both channels idle and stall in random
// bursts, the receiver holds off once for a long stretch, and the run ends
// at full rate.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_4x4_unit;
  import mm4_pkg::*;

  localparam int SIDE         = 4;
  localparam int CELLS        = SIDE * SIDE;
  localparam int ACC_W        = PROD_W + 4;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 310;

  localparam logic [IDX_W-1:0]         LAST_POS = IDX_W'(CELLS - 1);
  localparam logic signed [DATA_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sh0001_0000;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [IDX_W-1:0]         in_elem_index;
  logic signed [DATA_W-1:0] in_left_value;
  logic signed [DATA_W-1:0] in_right_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] out_product_value;
  logic                     out_last_elem;

  // Predicted matrix contents and pending product elements
  logic signed [DATA_W-1:0] left_mat [CELLS];
  logic signed [DATA_W-1:0] right_mat [CELLS];
  product_t                 product_q [$];

  int  err_count        = 0;
  int  items_sent       = 0;
  int  runs_started     = 0;
  int  products_checked = 0;
  int  cycle_count      = 0;
  int  rx_gap_left      = 0;
  bit  tx_idling        = 1'b0;
  bit  rx_idling        = 1'b0;
  bit  hold_req         = 1'b0;
  bit  long_hold        = 1'b0;

  matrix_multiply_4x4_unit #(
    .DIM(SIDE)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_elem_index    (in_elem_index),
    .in_left_value    (in_left_value),
    .in_right_value   (in_right_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_product_value(out_product_value),
    .out_last_elem    (out_last_elem)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Row-by-column sum of products, floor-shifted and clamped to 32 bits
  function automatic logic signed [DATA_W-1:0] dot_q16(int row, int col);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lhs;
    logic signed [ACC_W-1:0] rhs;
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    int                      k;
    acc    = '0;
    hi_lim = ACC_W'(Q_MAX);
    lo_lim = ACC_W'(Q_MIN);
    for (k = 0; k < SIDE; k++) begin
      lhs = ACC_W'(left_mat[row * SIDE + k]);
      rhs = ACC_W'(right_mat[k * SIDE + col]);
      acc = acc + lhs * rhs;
    end
    acc = acc >>> FRAC_W;
    if (acc > hi_lim) return Q_MAX;
    if (acc < lo_lim) return Q_MIN;
    return acc[DATA_W-1:0];
  endfunction

  // Store one element pair; the last position queues a full product
  task automatic apply_load(input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] lval,
                            input logic signed [DATA_W-1:0] rval);
    product_t p;
    int       pos;
    left_mat[idx]  = lval;
    right_mat[idx] = rval;
    if (idx == LAST_POS) begin
      runs_started++;
      for (pos = 0; pos < CELLS; pos++) begin
        p.index   = IDX_W'(pos);
        p.value   = dot_q16(pos / SIDE, pos % SIDE);
        p.is_last = (pos == CELLS - 1);
        product_q.push_back(p);
      end
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
      4, 5:    return $urandom;
      default: return int'($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_count++;
  endtask

  // Offer one transaction, with an optional idle burst ahead of it
  task automatic send_elem(input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] lval,
                           input logic signed [DATA_W-1:0] rval);
    int gap;
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_elem_index  <= idx;
    in_left_value  <= lval;
    in_right_value <= rval;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    apply_load(idx, lval, rval);
  endtask

  // Load positions 0..14 with random content, then trigger on the last
  task automatic send_matrix(input bit shuffled);
    int order [CELLS-1];
    int i;
    int j;
    int tmp;
    for (i = 0; i < CELLS - 1; i++) order[i] = i;
    if (shuffled) begin
      for (i = CELLS - 2; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (i = 0; i < CELLS - 1; i++) send_elem(IDX_W'(order[i]), rand_q16(), rand_q16());
    send_elem(LAST_POS, rand_q16(), rand_q16());
  endtask

  // Receiver: random stall bursts, or a long hold-off on request
  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (rx_gap_left > 0) begin
      out_stall   <= 1'b1;
      rx_gap_left <= rx_gap_left - 1;
    end else if (rx_idling && $urandom_range(0, 5) == 0) begin
      out_stall   <= 1'b1;
      rx_gap_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Count out the long receiver hold-off
  always begin : hold_off
    wait (hold_req);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
    hold_req  = 1'b0;
  end

  // Compare each accepted product element with the oldest prediction
  always @(posedge clk) begin : check_products
    product_t exp_p;
    if (rst_n === 1'b1) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid && out_stall == 1'b0) begin
        if (product_q.size() == 0) begin
          report_mismatch($sformatf("unexpected product index %0d value %h",
                                    out_index, out_product_value));
        end else begin
          exp_p = product_q.pop_front();
          if (out_index !== exp_p.index)
            report_mismatch($sformatf("out_index expected %0d got %0d",
                                      exp_p.index, out_index));
          if (out_product_value !== exp_p.value)
            report_mismatch($sformatf("index %0d product expected %h got %h",
                                      exp_p.index, exp_p.value, out_product_value));
          if (out_last_elem !== exp_p.is_last)
            report_mismatch($sformatf("index %0d last flag expected %b got %b",
                                      exp_p.index, exp_p.is_last, out_last_elem));
          products_checked++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  // Fill both matrices in order: identity on the left; extremes, zero and -1.0 on the right
  task automatic test_identity_load();
    int                       i;
    logic signed [DATA_W-1:0] rval;
    for (i = 0; i < CELLS; i++) begin
      case (i % 4)
        0:       rval = Q_MAX;
        1:       rval = Q_MIN;
        2:       rval = '0;
        default: rval = -Q_ONE;
      endcase
      send_elem(IDX_W'(i), (i / SIDE == i % SIDE) ? Q_ONE : '0, rval);
    end
  endtask

  // Overwrite rows and a column to drive both saturation limits
  task automatic test_saturation();
    send_elem(IDX_W'(0),  Q_MAX, Q_MAX);
    send_elem(IDX_W'(1),  Q_MAX, rand_q16());
    send_elem(IDX_W'(2),  Q_MAX, rand_q16());
    send_elem(IDX_W'(3),  Q_MAX, rand_q16());
    send_elem(IDX_W'(4),  Q_MIN, Q_MAX);
    send_elem(IDX_W'(5),  Q_MIN, rand_q16());
    send_elem(IDX_W'(6),  Q_MIN, rand_q16());
    send_elem(IDX_W'(7),  Q_MIN, rand_q16());
    send_elem(IDX_W'(8),  rand_q16(), Q_MAX);
    send_elem(IDX_W'(12), rand_q16(), Q_MAX);
    send_elem(LAST_POS,   Q_MIN, Q_MIN);
  endtask

  // Mostly whole matrices, some partial reloads and stray loads
  task automatic test_random_runs();
    int stop_at;
    int n;
    int kind;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      kind      = $urandom_range(0, 9);
      if (kind < 7) begin
        send_matrix(1'($urandom_range(0, 1)));
      end else if (kind < 9) begin
        n = $urandom_range(1, 8);
        repeat (n) send_elem(IDX_W'($urandom_range(0, CELLS - 2)), rand_q16(), rand_q16());
        send_elem(LAST_POS, rand_q16(), rand_q16());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_elem(IDX_W'($urandom_range(0, CELLS - 1)), rand_q16(), rand_q16());
      end
    end
  endtask

  // Hold the receiver off while two matrices stream in back to back
  task automatic test_backpressure();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    hold_req  = 1'b1;
    repeat (2) send_matrix(1'b0);
    wait (!hold_req);
  endtask

  // Finish with no idling on either side
  task automatic test_full_rate();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    repeat (3) send_matrix(1'b1);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_elem_index  = '0;
    in_left_value  = '0;
    in_right_value = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    tx_idling = 1'b1;
    rx_idling = 1'b1;
    test_identity_load();
    test_saturation();
    test_random_runs();
    test_backpressure();
    test_full_rate();

    @(negedge clk);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d element pairs over %0d product runs, %0d elements checked.",
             items_sent, runs_started, products_checked);
    $display("Covered saturation, shuffled and partial reloads, a %0d-cycle hold-off "
             , HOLD_CYCLES, "and full-rate streaming.");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
